FILE: sv/pid_controller_with_angle_wrap_macros.svh
// Assertion macros shared by the PID controller RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef PID_CONTROLLER_WITH_ANGLE_WRAP_MACROS_SVH
`define PID_CONTROLLER_WITH_ANGLE_WRAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIDW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIDW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/pidw_pkg.sv
// Types and constants shared by the PID controller pipeline.
// No dependencies; imported by every module of the block.
package pidw_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [DATA_WIDTH:0]   wide_t;

	localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Angle handling works on the integer degree part of a Q value.
	localparam int TURN_DEG = 360;
	localparam int HALF_DEG = 180;
	localparam int HI_W     = DATA_WIDTH - FRAC_BITS;
	localparam int DEG_W    = 9;
	localparam int REM_W    = 10;
	localparam int ANG_W    = DEG_W + FRAC_BITS;
	localparam int QUO_W    = HI_W - 8;

	// Reciprocal of 360 for the degree quotient; the estimate is low by at most one.
	localparam int RECIP_SHIFT = HI_W + 9;
	localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / TURN_DEG;
	localparam int RECIP_W = $clog2(RECIP + 1);

	// The degree part is taken in offset binary; this is the offset modulo one turn.
	localparam int HI_OFFSET_DEG = int'((64'd1 << (HI_W - 1)) % TURN_DEG);

	localparam wide_t FULL_TURN = wide_t'(TURN_DEG) <<< FRAC_BITS;
	localparam wide_t HALF_TURN = wide_t'(HALF_DEG) <<< FRAC_BITS;

	// Product and term widths of the gain stage.
	localparam int PROD_W = 2 * DATA_WIDTH + 1;
	localparam int TERM_W = PROD_W - FRAC_BITS;
	localparam int SUM3_W = TERM_W + 2;

	typedef logic signed [TERM_W-1:0] term_t;

	typedef struct packed {
		data_t prop_gain;
		data_t integ_gain;
		data_t deriv_gain;
		data_t drive_min;
		data_t drive_max;
	} gain_cfg_t;

	typedef struct packed {
		data_t sum_min;
		data_t sum_max;
	} sum_lim_t;

endpackage

FILE: sv/pid_controller_with_angle_wrap.sv
// Top level of the positional PID controller with shortest-path angle error.
// Instantiates pidw_err, pidw_integ and pidw_mix; depends on pidw_pkg.

// Positional PID controller in signed Q16.16. Each input beat carries a measured value and
// a setpoint; each accepted beat yields exactly one output beat with the clamped drive and
// the error used for that step. While the output is not stalled, the block takes one beat
// per clock cycle; it has seven register stages, which a beat passes through in order.
// The rate of one beat per cycle is set by the integrator stage, whose add-and-clamp
// feedback on the error sum and the previous error is combinational between its state
// registers; the angle reduction and the three gain multipliers are pipelined around it.
// Each stage holds its beat while the next is full and cannot move on, so bubbles are
// squeezed out and the input keeps being taken while a finished result waits on a stalled
// output, until all seven stages hold a beat. In angle mode both inputs are reduced
// to [0, 360) degrees and the error is wrapped into (-180, 180]; otherwise the error is
// setpoint minus measured, saturated to 32 bits. The error sum is clamped to the sum limits
// before the integral gain is applied, and the total of the three terms is clamped to the
// drive limits; in both clamps the upper limit is tested first. Gains and limits are to be
// written through the configuration port only while no beat is in flight; the block does not
// enforce this. Written so, they take effect for the next beat accepted.
module pid_controller_with_angle_wrap (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_write,
	input  logic [2:0]      cfg_index,
	input  pidw_pkg::data_t cfg_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  pidw_pkg::data_t measured,
	input  pidw_pkg::data_t setpoint,
	output logic            out_valid,
	input  logic            out_stall,
	output pidw_pkg::data_t drive,
	output pidw_pkg::data_t error_value
);
	import pidw_pkg::*;

	// Register map of the configuration port.
	localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [2:0] REG_DRIVE_MIN  = 3'd3;
	localparam logic [2:0] REG_DRIVE_MAX  = 3'd4;
	localparam logic [2:0] REG_SUM_MIN    = 3'd5;
	localparam logic [2:0] REG_SUM_MAX    = 3'd6;
	localparam logic [2:0] REG_ANGLE_MODE = 3'd7;

	data_t prop_gain_q, integ_gain_q, deriv_gain_q;
	data_t drive_min_q, drive_max_q, sum_min_q, sum_max_q;
	logic  angle_mode_q;

	gain_cfg_t gains;
	sum_lim_t  lim;

	// Links between the three pipeline sections.
	logic  err_valid, err_stall;
	data_t err_val;
	logic  int_valid, int_stall;
	data_t int_err, int_isum;
	wide_t int_diff;

	// Configuration registers. The whole index space is populated, so every write
	// lands in one register; angle mode keeps only the low data bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			drive_min_q  <= DATA_MIN;
			drive_max_q  <= DATA_MAX;
			sum_min_q    <= DATA_MIN;
			sum_max_q    <= DATA_MAX;
			angle_mode_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data;
				REG_INTEG_GAIN: integ_gain_q <= cfg_data;
				REG_DERIV_GAIN: deriv_gain_q <= cfg_data;
				REG_DRIVE_MIN:  drive_min_q  <= cfg_data;
				REG_DRIVE_MAX:  drive_max_q  <= cfg_data;
				REG_SUM_MIN:    sum_min_q    <= cfg_data;
				REG_SUM_MAX:    sum_max_q    <= cfg_data;
				REG_ANGLE_MODE: angle_mode_q <= cfg_data[0];
			endcase
		end
	end

	assign gains = '{prop_gain:  prop_gain_q,
			integ_gain: integ_gain_q,
			deriv_gain: deriv_gain_q,
			drive_min:  drive_min_q,
			drive_max:  drive_max_q};
	assign lim = '{sum_min: sum_min_q, sum_max: sum_max_q};

	// Input register, angle reduction and error select.
	pidw_err u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_mode  (angle_mode_q),
		.up_valid    (in_valid),
		.up_stall    (in_stall),
		.measured    (measured),
		.setpoint    (setpoint),
		.dn_valid    (err_valid),
		.dn_stall    (err_stall),
		.error_value (err_val)
	);

	// Error sum with clamp and the error difference; the only loop in the block.
	pidw_integ u_integ (
		.clk      (clk),
		.arst_n   (arst_n),
		.lim      (lim),
		.up_valid (err_valid),
		.up_stall (err_stall),
		.err_in   (err_val),
		.dn_valid (int_valid),
		.dn_stall (int_stall),
		.err_out  (int_err),
		.isum_out (int_isum),
		.diff_out (int_diff)
	);

	// Gain products, term sum, drive clamp and the output register.
	pidw_mix u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.gains       (gains),
		.up_valid    (int_valid),
		.up_stall    (int_stall),
		.err_in      (int_err),
		.isum_in     (int_isum),
		.diff_in     (int_diff),
		.dn_valid    (out_valid),
		.dn_stall    (out_stall),
		.drive       (drive),
		.error_value (error_value)
	);

endmodule

FILE: sv/pidw_err.sv
// Error front end: input register, modulo-360 angle reduction and error select.
// Depends on pidw_pkg and the assertion macro header.
`include "pid_controller_with_angle_wrap_macros.svh"

module pidw_err (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           angle_mode,
	input  logic           up_valid,
	output logic           up_stall,
	input  pidw_pkg::data_t measured,
	input  pidw_pkg::data_t setpoint,
	output logic           dn_valid,
	input  logic           dn_stall,
	output pidw_pkg::data_t error_value
);
	import pidw_pkg::*;

	localparam int MUL_W = HI_W + RECIP_W;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	data_t meas_s1, setp_s1;
	data_t meas_s2, setp_s2;
	logic [QUO_W-1:0] quo_m_s2, quo_s_s2;
	data_t meas_s3, setp_s3;
	logic [ANG_W-1:0] ang_m_s3, ang_s_s3;
	data_t error_s4;

	logic [HI_W-1:0] u_m_s1, u_s_s1, u_m_s2, u_s_s2;
	data_t err_next;

	// Degree part in offset binary, so that it reads as an unsigned number.
	function automatic logic [HI_W-1:0] offset_hi(data_t x);
		return {~x[DATA_WIDTH-1], x[DATA_WIDTH-2:FRAC_BITS]};
	endfunction

	function automatic logic [QUO_W-1:0] turn_quot(logic [HI_W-1:0] u);
		logic [MUL_W-1:0] prod;
		prod = MUL_W'(u) * MUL_W'(RECIP);
		return QUO_W'(prod >> RECIP_SHIFT);
	endfunction

	// Remainder of the offset degree part, corrected for the estimate and the offset.
	function automatic logic [ANG_W-1:0] turn_angle(logic [HI_W-1:0] u,
		logic [QUO_W-1:0] q, logic [FRAC_BITS-1:0] frac);
		logic [HI_W-1:0] r_full;
		logic [REM_W-1:0] r;
		logic [DEG_W-1:0] deg;
		r_full = u - HI_W'(q) * HI_W'(TURN_DEG);
		r = REM_W'(r_full);
		if (r >= REM_W'(TURN_DEG + HI_OFFSET_DEG)) begin
			deg = DEG_W'(r - REM_W'(TURN_DEG + HI_OFFSET_DEG));
		end else if (r >= REM_W'(HI_OFFSET_DEG)) begin
			deg = DEG_W'(r - REM_W'(HI_OFFSET_DEG));
		end else begin
			deg = DEG_W'(r + REM_W'(TURN_DEG - HI_OFFSET_DEG));
		end
		return {deg, frac};
	endfunction

	assign en_s4 = !v_s4 || !dn_stall;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign up_stall = !en_s1;

	assign u_m_s1 = offset_hi(meas_s1);
	assign u_s_s1 = offset_hi(setp_s1);
	assign u_m_s2 = offset_hi(meas_s2);
	assign u_s_s2 = offset_hi(setp_s2);

	always_comb begin
		wide_t lin, ang_d, ang_w;
		lin = wide_t'(setp_s3) - wide_t'(meas_s3);
		ang_d = wide_t'(ang_s_s3) - wide_t'(ang_m_s3);
		if (ang_d > HALF_TURN) begin
			ang_w = ang_d - FULL_TURN;
		end else if (ang_d <= -HALF_TURN) begin
			ang_w = ang_d + FULL_TURN;
		end else begin
			ang_w = ang_d;
		end
		if (angle_mode) begin
			err_next = DATA_WIDTH'(ang_w);
		end else if (lin[DATA_WIDTH] != lin[DATA_WIDTH-1]) begin
			err_next = lin[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
		end else begin
			err_next = DATA_WIDTH'(lin);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= up_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && up_valid) begin
			meas_s1 <= measured;
			setp_s1 <= setpoint;
		end
		if (en_s2 && v_s1) begin
			meas_s2 <= meas_s1;
			setp_s2 <= setp_s1;
			quo_m_s2 <= turn_quot(u_m_s1);
			quo_s_s2 <= turn_quot(u_s_s1);
		end
		if (en_s3 && v_s2) begin
			meas_s3 <= meas_s2;
			setp_s3 <= setp_s2;
			ang_m_s3 <= turn_angle(u_m_s2, quo_m_s2, meas_s2[FRAC_BITS-1:0]);
			ang_s_s3 <= turn_angle(u_s_s2, quo_s_s2, setp_s2[FRAC_BITS-1:0]);
		end
		if (en_s4 && v_s3) begin
			error_s4 <= err_next;
		end
	end

	assign dn_valid = v_s4;
	assign error_value = error_s4;

	`PIDW_ASSERT_SAME(a_quot_in_range, clk, arst_n, v_s2,
		(HI_W'(quo_m_s2) * HI_W'(TURN_DEG) <= u_m_s2) &&
		(u_m_s2 - HI_W'(quo_m_s2) * HI_W'(TURN_DEG) < HI_W'(2 * TURN_DEG)),
		"degree quotient estimate off by more than one")
	`PIDW_ASSERT_SAME(a_deg_reduced, clk, arst_n, v_s3,
		(ang_m_s3[ANG_W-1:FRAC_BITS] < DEG_W'(TURN_DEG)) &&
		(ang_s_s3[ANG_W-1:FRAC_BITS] < DEG_W'(TURN_DEG)),
		"reduced angle not below one turn")

endmodule

FILE: sv/pidw_integ.sv
// Integrator stage: clamped error sum and previous error held as loop state.
// Depends on pidw_pkg and the assertion macro header.
`include "pid_controller_with_angle_wrap_macros.svh"

module pidw_integ (
	input  logic            clk,
	input  logic            arst_n,
	input  pidw_pkg::sum_lim_t lim,
	input  logic            up_valid,
	output logic            up_stall,
	input  pidw_pkg::data_t err_in,
	output logic            dn_valid,
	input  logic            dn_stall,
	output pidw_pkg::data_t err_out,
	output pidw_pkg::data_t isum_out,
	output pidw_pkg::wide_t diff_out
);
	import pidw_pkg::*;

	logic v_s5, en_s5, fire;
	data_t integ_q, prev_err_q;
	data_t error_s5, isum_s5;
	wide_t diff_s5;
	data_t isum_next;
	wide_t diff_next;

	assign en_s5 = !v_s5 || !dn_stall;
	assign up_stall = !en_s5;
	assign fire = up_valid && en_s5;

	// Upper limit is checked first, so it wins when the limits are crossed.
	always_comb begin
		wide_t sum;
		sum = wide_t'(integ_q) + wide_t'(err_in);
		if (sum > wide_t'(lim.sum_max)) begin
			isum_next = lim.sum_max;
		end else if (sum < wide_t'(lim.sum_min)) begin
			isum_next = lim.sum_min;
		end else begin
			isum_next = DATA_WIDTH'(sum);
		end
		diff_next = wide_t'(err_in) - wide_t'(prev_err_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			integ_q <= '0;
			prev_err_q <= '0;
		end else begin
			if (en_s5) v_s5 <= up_valid;
			if (fire) begin
				integ_q <= isum_next;
				prev_err_q <= err_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			error_s5 <= err_in;
			isum_s5 <= isum_next;
			diff_s5 <= diff_next;
		end
	end

	assign dn_valid = v_s5;
	assign err_out = error_s5;
	assign isum_out = isum_s5;
	assign diff_out = diff_s5;

	`PIDW_ASSERT_NEXT(a_state_only_on_beat, clk, arst_n, !fire,
		$stable(integ_q) && $stable(prev_err_q), "integrator state moved without an item")

endmodule

FILE: sv/pidw_mix.sv
// Gain stage: three products, floor scaling, term sum and drive clamp.
// Depends on pidw_pkg and the assertion macro header.
`include "pid_controller_with_angle_wrap_macros.svh"

module pidw_mix (
	input  logic            clk,
	input  logic            arst_n,
	input  pidw_pkg::gain_cfg_t gains,
	input  logic            up_valid,
	output logic            up_stall,
	input  pidw_pkg::data_t err_in,
	input  pidw_pkg::data_t isum_in,
	input  pidw_pkg::wide_t diff_in,
	output logic            dn_valid,
	input  logic            dn_stall,
	output pidw_pkg::data_t drive,
	output pidw_pkg::data_t error_value
);
	import pidw_pkg::*;

	logic v_s6, v_s7, en_s6, en_s7;
	term_t term_p_s6, term_i_s6, term_d_s6;
	data_t error_s6;
	data_t drive_s7, error_s7;

	logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
	data_t drive_next;

	assign en_s7 = !v_s7 || !dn_stall;
	assign en_s6 = !v_s6 || en_s7;
	assign up_stall = !en_s6;

	// Full products; the arithmetic shift gives rounding toward minus infinity.
	// At this width a scaled term stays inside the signed 49-bit term range (below 2^48).
	assign prod_p = PROD_W'(gains.prop_gain) * PROD_W'(err_in);
	assign prod_i = PROD_W'(gains.integ_gain) * PROD_W'(isum_in);
	assign prod_d = PROD_W'(gains.deriv_gain) * PROD_W'(diff_in);

	always_comb begin
		logic signed [SUM3_W-1:0] total;
		total = SUM3_W'(term_p_s6) + SUM3_W'(term_i_s6) + SUM3_W'(term_d_s6);
		if (total > SUM3_W'(gains.drive_max)) begin
			drive_next = gains.drive_max;
		end else if (total < SUM3_W'(gains.drive_min)) begin
			drive_next = gains.drive_min;
		end else begin
			drive_next = DATA_WIDTH'(total);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s6) v_s6 <= up_valid;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6 && up_valid) begin
			term_p_s6 <= TERM_W'(prod_p >>> FRAC_BITS);
			term_i_s6 <= TERM_W'(prod_i >>> FRAC_BITS);
			term_d_s6 <= TERM_W'(prod_d >>> FRAC_BITS);
			error_s6 <= err_in;
		end
		if (en_s7 && v_s6) begin
			drive_s7 <= drive_next;
			error_s7 <= error_s6;
		end
	end

	assign dn_valid = v_s7;
	assign drive = drive_s7;
	assign error_value = error_s7;

	`PIDW_ASSERT_SAME(a_out_from_stage, clk, arst_n, $rose(v_s7), $past(v_s6),
		"result appeared without an item in the product stage")

endmodule
